@@ hw/rtl/psa_pkg.sv @@
// Shared types, codes and defaults for the process slot allocator.
`default_nettype none

package psa_pkg;

  // Default number of slots in the pool.
  localparam int POOL_SIZE_DEF = 32;

  // Fixed widths of the transaction fields.
  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;

  // Request action codes.
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  // One request transaction.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot_id;
  } psa_req_t;

  // One response transaction.
  typedef struct packed {
    logic [SLOT_W-1:0]   result_id;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   free_count;
  } psa_rsp_t;

  // Shift command broadcast to every cell of the free stack.
  typedef struct packed {
    logic push;
    logic pop;
  } psa_shift_t;

endpackage : psa_pkg

`default_nettype wire

@@ hw/rtl/psa_cell.sv @@
// One entry of the free stack: holds an id and shifts with its neighbors.
`default_nettype none

module psa_cell #(
  parameter int ID_W     = 6,
  parameter int RESET_ID = 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire psa_pkg::psa_shift_t shift,
  input  wire logic [ID_W-1:0]    above,
  input  wire logic [ID_W-1:0]    below,
  output logic      [ID_W-1:0]    value
);

  // A push moves every entry one place deeper; a pop moves every entry up.
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= ID_W'(RESET_ID);
    end else if (shift.push) begin
      value <= above;
    end else if (shift.pop) begin
      value <= below;
    end
  end

endmodule : psa_cell

`default_nettype wire

@@ hw/rtl/process_slot_allocator.sv @@
// Top level of the process slot allocator: free stack, allocated flags and response register.
`default_nettype none

// Process slot allocator. A pool of slot ids 1..POOL_SIZE is handed out from a
// last-in first-out free stack built as a row of shifting cells, id 1 on top.
// Request channel: a transaction (action, slot_id) is taken at a rising edge
// where start is high and busy is low. Actions are allocate (pop the top id),
// free (push an allocated id back) and look up (check that an id is allocated).
// Response channel: every request gives exactly one response (result_id,
// status, free_count), shown for one cycle with done high, on the cycle right
// after the request. The receiver cannot stall; responses are never held.
// A new request may be issued every cycle: the stack cells, the count and the
// flag row all update at the same edge, so busy stays low.
// A free of an out-of-range or unallocated id is flagged invalid and changes
// nothing. Reset (synchronous, active high) refills the stack with every id,
// id 1 on top, clears all allocated flags and drops done.

module process_slot_allocator #(
  parameter int POOL_SIZE = psa_pkg::POOL_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire psa_pkg::psa_req_t req,
  output logic                   done,
  output psa_pkg::psa_rsp_t      rsp
);

  localparam int ID_W  = $clog2(POOL_SIZE + 1);
  localparam int IDX_W = $clog2(POOL_SIZE);

  logic                   accept;
  psa_pkg::psa_shift_t    shift;
  logic [ID_W-1:0]        push_id;
  logic [ID_W-1:0]        cell_val [POOL_SIZE];
  logic [ID_W-1:0]        top_id;
  logic [ID_W-1:0]        stack_count;
  logic [ID_W-1:0]        stack_count_next;
  logic [POOL_SIZE-1:0]   in_use;
  logic [POOL_SIZE-1:0]   in_use_next;
  logic                   slot_ok;
  logic [IDX_W-1:0]       slot_idx;
  logic [IDX_W-1:0]       top_idx;
  psa_pkg::psa_rsp_t      rsp_next;

  // Every request is completed as it is taken, so the block is always ready.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode the requested slot.
  assign slot_idx = IDX_W'(req.slot_id - psa_pkg::SLOT_W'(1));
  assign slot_ok  = (req.slot_id != '0) && (32'(req.slot_id) <= 32'(POOL_SIZE))
                    && in_use[slot_idx];
  assign push_id  = ID_W'(req.slot_id);
  assign top_id   = cell_val[0];
  assign top_idx  = IDX_W'(top_id - ID_W'(1));

  // Row of stack cells; cell 0 is the top of the stack.
  for (genvar k = 0; k < POOL_SIZE; k++) begin : g_cell
    logic [ID_W-1:0] above;
    logic [ID_W-1:0] below;
    if (k == 0) begin : g_first
      assign above = push_id;
    end else begin : g_inner_a
      assign above = cell_val[k-1];
    end
    if (k == POOL_SIZE - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner_b
      assign below = cell_val[k+1];
    end
    psa_cell #(
      .ID_W     (ID_W),
      .RESET_ID (k + 1)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .above (above),
      .below (below),
      .value (cell_val[k])
    );
  end

  // Request decode: shift command, count and flag updates, and the response.
  always_comb begin
    shift              = '0;
    stack_count_next   = stack_count;
    in_use_next        = in_use;
    rsp_next.result_id = '0;
    rsp_next.status    = psa_pkg::ST_INVALID;
    if (accept) begin
      case (req.action)
        psa_pkg::ACT_ALLOC: begin
          if (stack_count == '0) begin
            rsp_next.status = psa_pkg::ST_EMPTY;
          end else begin
            shift.pop             = 1'b1;
            stack_count_next      = stack_count - ID_W'(1);
            in_use_next[top_idx]  = 1'b1;
            rsp_next.result_id    = psa_pkg::SLOT_W'(top_id);
            rsp_next.status       = psa_pkg::ST_OK;
          end
        end
        psa_pkg::ACT_FREE: begin
          if (slot_ok) begin
            in_use_next[slot_idx] = 1'b0;
            if (stack_count < ID_W'(POOL_SIZE)) begin
              shift.push       = 1'b1;
              stack_count_next = stack_count + ID_W'(1);
            end
            rsp_next.result_id = req.slot_id;
            rsp_next.status    = psa_pkg::ST_OK;
          end
        end
        psa_pkg::ACT_LOOKUP: begin
          if (slot_ok) begin
            rsp_next.result_id = req.slot_id;
            rsp_next.status    = psa_pkg::ST_OK;
          end
        end
        default: begin
          rsp_next.status = psa_pkg::ST_INVALID;
        end
      endcase
    end
    rsp_next.free_count = psa_pkg::SLOT_W'(stack_count_next);
  end

  // Stack depth and allocated flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= ID_W'(POOL_SIZE);
      in_use      <= '0;
    end else begin
      stack_count <= stack_count_next;
      in_use      <= in_use_next;
    end
  end

  // Response strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // Response payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Every slot is either on the free stack or flagged as allocated.
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    ($countones(in_use) + int'(stack_count)) == POOL_SIZE)
    else $error("slot count mismatch between stack and flags");

  // Each accepted request gives a response on the next cycle.
  a_resp: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("missing response");

  // A failed request never returns an id.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != psa_pkg::ST_OK) |-> (rsp.result_id == '0))
    else $error("failed request returned an id");

  // The reported free count tracks the stack depth.
  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.free_count == psa_pkg::SLOT_W'(stack_count)))
    else $error("free count does not match stack depth");

  // A successful allocation marks the returned slot as allocated.
  a_alloc_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == psa_pkg::ACT_ALLOC && stack_count != '0)
      |=> in_use[$past(top_idx)])
    else $error("allocated slot not flagged");

endmodule : process_slot_allocator

`default_nettype wire
